### src/crt_pkg.sv
// Shared constants, types and helper functions for the claim retry budget tracker.
// No dependencies; every other file in src except crt_ram imports this package.
package crt_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 8;
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W      = $clog2(RING_DEPTH + 8) + 1;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int OP_W     = 2;
  localparam int KEY_W    = 64;
  localparam int CH_W     = 64;
  localparam int ARM_W    = 2;
  localparam int CAUSE_W  = 2;
  localparam int IDX_W    = 3;
  localparam int BUDGET_W = 8;
  localparam int HELD_W   = 4;
  localparam int ENTRY_W  = CH_W + ARM_W + CAUSE_W;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0]          REG_RETRY_BUDGET = 1'b0;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET     = 8'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_REFUSE = 2'd0,
    CMD_RESET  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch_in;
    logic begin_op;
    logic clear_all;
    logic rd_entry;
    logic rd_search;
    logic search_inc;
    logic wr_match;
    logic wr_new;
    logic count_inc;
    logic load_out;
  } dp_ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic refusal;
    logic present;
    logic search_more;
    logic match;
  } dp_stat_t;

  // Physical ring slot of logical position off, counted from the oldest slot head
  function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W-1:0] head,
                                                  input logic [SUM_W-1:0]  off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + off;
    if (sum >= SUM_W'(RING_DEPTH)) begin
      sum = sum - SUM_W'(RING_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

### src/crt_if.sv
// Valid/ready channel interfaces for the tracker's command and result transactions.
// Depends on crt_pkg for field widths.
interface crt_in_if;
  import crt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [OP_W-1:0]      operation;
  logic [KEY_W-1:0]     key_id;
  logic [CH_W-1:0]      channel_id;
  logic                 channel_present;
  logic [ARM_W-1:0]     arm;
  logic [CAUSE_W-1:0]   cause;
  logic [IDX_W-1:0]     entry_index;

  modport source (
    output valid, cmd, operation, key_id, channel_id, channel_present, arm, cause,
           entry_index,
    input  ready
  );
  modport sink (
    input  valid, cmd, operation, key_id, channel_id, channel_present, arm, cause,
           entry_index,
    output ready
  );
endinterface

interface crt_out_if;
  import crt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 exhausted;
  logic [BUDGET_W-1:0]  refusal_count;
  logic [HELD_W-1:0]    entries_held;
  logic                 entry_valid;
  logic [CH_W-1:0]      entry_channel;
  logic [ARM_W-1:0]     entry_arm;
  logic [CAUSE_W-1:0]   entry_cause;

  modport source (
    output valid, exhausted, refusal_count, entries_held, entry_valid, entry_channel,
           entry_arm, entry_cause,
    input  ready
  );
  modport sink (
    input  valid, exhausted, refusal_count, entries_held, entry_valid, entry_channel,
           entry_arm, entry_cause,
    output ready
  );
endinterface

### src/claim_retry_budget_tracker.sv
// Claim retry budget tracker top level: configuration register, controller and datapath.
// Depends on crt_pkg, crt_if, crt_ram, crt_dpath and crt_ctrl.
//
// Usage:
//   in_chan carries one command transaction: record a refused claim, reset after a
//   successful claim, or read one slot of the ring of refusing {channel, arm} pairs.
//   out_chan returns exactly one result transaction per command.
//   The cfg_ APB port holds retry_budget at byte address 0 (reset value 8); write it
//   only while no command is in flight.
// Sequence (states of crt_ctrl), one command at a time:
//   reset, read, unused and ignored commands: decode, result; refusal without a channel:
//   decode, count, result. Each held entry compared takes a read and a compare step on
//   the single registered RAM read port; a match rewrites that entry, else the pair is
//   appended, then count and result; the next command is accepted after the result loads.
// Reset:
//   rst_n is synchronous; it clears the budget to 8, the count, the operation and the
//   ring fill. Ring contents are not cleared: only filled slots reach a result or a compare.
// Stall:
//   The result waits in an output register; the next command is accepted meanwhile,
//   and its own result is held back until the waiting one is taken.
module claim_retry_budget_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  crt_in_if.sink                          in_chan,
  crt_out_if.source                       out_chan,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [crt_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [crt_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [crt_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import crt_pkg::*;

  logic [BUDGET_W-1:0] budget_r;
  logic                cfg_sel_budget;
  logic                in_ready;
  logic                out_valid;
  dp_ctrl_t            ctl;
  dp_stat_t            stat;

  // Configuration register
  assign cfg_sel_budget = (cfg_paddr[CFG_ADDR_W-1:2] == REG_RETRY_BUDGET);
  assign cfg_pready     = 1'b1;
  assign cfg_prdata     = cfg_sel_budget ? CFG_DATA_W'(budget_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_budget) begin
      budget_r <= cfg_pwdata[BUDGET_W-1:0];
    end
  end

  crt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .ctl       (ctl),
    .stat      (stat)
  );

  crt_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .stat              (stat),
    .budget            (budget_r),
    .i_cmd             (in_chan.cmd),
    .i_operation       (in_chan.operation),
    .i_key_id          (in_chan.key_id),
    .i_channel_id      (in_chan.channel_id),
    .i_channel_present (in_chan.channel_present),
    .i_arm             (in_chan.arm),
    .i_cause           (in_chan.cause),
    .i_entry_index     (in_chan.entry_index),
    .o_exhausted       (out_chan.exhausted),
    .o_refusal_count   (out_chan.refusal_count),
    .o_entries_held    (out_chan.entries_held),
    .o_entry_valid     (out_chan.entry_valid),
    .o_entry_channel   (out_chan.entry_channel),
    .o_entry_arm       (out_chan.entry_arm),
    .o_entry_cause     (out_chan.entry_cause)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

  // One command at a time: no acceptance in the cycle after an acceptance
  a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_ready |=> !in_ready)
    else $error("command accepted while previous one in progress");

  // Entry fields are zero unless a read hit a held slot
  a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_chan.entry_valid |->
      (out_chan.entry_channel == '0) && (out_chan.entry_arm == '0)
      && (out_chan.entry_cause == '0))
    else $error("entry fields nonzero without a valid entry");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result pending or busy after reset");

endmodule

### src/crt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module crt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/crt_dpath.sv
// Datapath: input capture, operation/count registers, ring pointers, ring RAM and result register.
// Depends on crt_pkg and crt_ram; driven by commands from crt_ctrl.
module crt_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crt_pkg::dp_ctrl_t             ctl,
  output crt_pkg::dp_stat_t             stat,
  input  logic [crt_pkg::BUDGET_W-1:0]  budget,
  input  logic [crt_pkg::CMD_W-1:0]     i_cmd,
  input  logic [crt_pkg::OP_W-1:0]      i_operation,
  input  logic [crt_pkg::KEY_W-1:0]     i_key_id,
  input  logic [crt_pkg::CH_W-1:0]      i_channel_id,
  input  logic                          i_channel_present,
  input  logic [crt_pkg::ARM_W-1:0]     i_arm,
  input  logic [crt_pkg::CAUSE_W-1:0]   i_cause,
  input  logic [crt_pkg::IDX_W-1:0]     i_entry_index,
  output logic                          o_exhausted,
  output logic [crt_pkg::BUDGET_W-1:0]  o_refusal_count,
  output logic [crt_pkg::HELD_W-1:0]    o_entries_held,
  output logic                          o_entry_valid,
  output logic [crt_pkg::CH_W-1:0]      o_entry_channel,
  output logic [crt_pkg::ARM_W-1:0]     o_entry_arm,
  output logic [crt_pkg::CAUSE_W-1:0]   o_entry_cause
);
  import crt_pkg::*;

  // Captured transaction
  cmd_t               cmd_r;
  logic [OP_W-1:0]    op_r;
  logic [KEY_W-1:0]   key_r;
  logic [CH_W-1:0]    ch_r;
  logic               present_r;
  logic [ARM_W-1:0]   arm_r;
  logic [CAUSE_W-1:0] cause_r;
  logic [IDX_W-1:0]   idx_r;

  // Tracking state
  logic [OP_W-1:0]     cur_op_r;
  logic [KEY_W-1:0]    cur_key_r;
  logic [BUDGET_W-1:0] count_r;
  logic [FILL_W-1:0]   fill_r;
  logic [ADDR_W-1:0]   head_r;

  // Search state
  logic [FILL_W-1:0]   si_r;
  logic [ADDR_W-1:0]   addr_r;

  // Result register
  logic                exh_r;
  logic [BUDGET_W-1:0] cnt_out_r;
  logic [HELD_W-1:0]   held_r;
  logic                ev_r;
  logic [CH_W-1:0]     ech_r;
  logic [ARM_W-1:0]    earm_r;
  logic [CAUSE_W-1:0]  ecause_r;

  logic                new_op;
  logic                ring_full;
  logic                hit;
  logic                exh;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic [ENTRY_W-1:0]  rd_data;

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      cmd_r     <= cmd_t'(i_cmd);
      op_r      <= i_operation;
      key_r     <= i_key_id;
      ch_r      <= i_channel_id;
      present_r <= i_channel_present;
      arm_r     <= i_arm;
      cause_r   <= i_cause;
      idx_r     <= i_entry_index;
    end
  end

  assign new_op    = (cur_op_r != op_r) || (cur_key_r != key_r);
  assign ring_full = (fill_r >= FILL_W'(RING_DEPTH));

  // Operation, count and ring pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_op_r  <= '0;
      cur_key_r <= '0;
      count_r   <= '0;
      fill_r    <= '0;
      head_r    <= '0;
    end else begin
      if (ctl.clear_all || (ctl.begin_op && new_op)) begin
        cur_op_r  <= ctl.clear_all ? '0 : op_r;
        cur_key_r <= ctl.clear_all ? '0 : key_r;
        count_r   <= '0;
        fill_r    <= '0;
        head_r    <= '0;
      end
      if (ctl.wr_new) begin
        if (ring_full) begin
          head_r <= wrap_addr(head_r, SUM_W'(1));
        end else begin
          fill_r <= fill_r + FILL_W'(1);
        end
      end
      if (ctl.count_inc && (count_r < budget)) begin
        count_r <= count_r + BUDGET_W'(1);
      end
    end
  end

  // Walk the ring from the oldest entry
  always_ff @(posedge clk) begin
    if (ctl.begin_op) begin
      si_r <= '0;
    end else if (ctl.search_inc) begin
      si_r <= si_r + FILL_W'(1);
    end
    if (ctl.rd_search) begin
      addr_r <= rd_addr;
    end
  end

  // Ring RAM access
  assign rd_en   = ctl.rd_entry || ctl.rd_search;
  assign rd_addr = ctl.rd_entry ? wrap_addr(head_r, SUM_W'(idx_r))
                                : wrap_addr(head_r, SUM_W'(si_r));
  assign wr_en   = ctl.wr_match || ctl.wr_new;
  assign wr_addr = ctl.wr_match ? addr_r
                 : (ring_full ? head_r : wrap_addr(head_r, SUM_W'(fill_r)));
  assign wr_data = {ch_r, arm_r, cause_r};

  crt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Status to the controller
  assign stat.cmd         = cmd_r;
  assign stat.refusal     = (cmd_r == CMD_REFUSE) && (op_r != '0);
  assign stat.present     = present_r;
  assign stat.search_more = (si_r < fill_r);
  assign stat.match       = (rd_data[ENTRY_W-1:ARM_W+CAUSE_W] == ch_r)
                         && (rd_data[ARM_W+CAUSE_W-1:CAUSE_W] == arm_r);

  // Result fields
  assign hit = (cmd_r == CMD_READ) && (SUM_W'(idx_r) < SUM_W'(fill_r));
  assign exh = ((cmd_r != CMD_REFUSE) || (op_r != '0)) && (cur_op_r != '0)
            && (count_r >= budget);

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      exh_r     <= exh;
      cnt_out_r <= count_r;
      held_r    <= HELD_W'(fill_r);
      ev_r      <= hit;
      ech_r     <= hit ? rd_data[ENTRY_W-1:ARM_W+CAUSE_W] : '0;
      earm_r    <= hit ? rd_data[ARM_W+CAUSE_W-1:CAUSE_W] : '0;
      ecause_r  <= hit ? rd_data[CAUSE_W-1:0] : '0;
    end
  end

  assign o_exhausted     = exh_r;
  assign o_refusal_count = cnt_out_r;
  assign o_entries_held  = held_r;
  assign o_entry_valid   = ev_r;
  assign o_entry_channel = ech_r;
  assign o_entry_arm     = earm_r;
  assign o_entry_cause   = ecause_r;

endmodule

### src/crt_ctrl.sv
// Controller state machine: sequences decode, ring search, ring update, count and result.
// Depends on crt_pkg for the command and status structs.
module crt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output crt_pkg::dp_ctrl_t  ctl,
  input  crt_pkg::dp_stat_t  stat
);
  import crt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_APPEND,
    S_COUNT,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // Next state and datapath commands
  always_comb begin
    ctl           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.refusal) begin
          ctl.begin_op = 1'b1;
          state_nxt    = stat.present ? S_SRCH_RD : S_COUNT;
        end else begin
          unique case (stat.cmd)
            CMD_RESET: ctl.clear_all = 1'b1;
            CMD_READ:  ctl.rd_entry  = 1'b1;
            default:   ;
          endcase
          state_nxt = S_RESP;
        end
      end
      S_SRCH_RD: begin
        if (stat.search_more) begin
          ctl.rd_search = 1'b1;
          state_nxt     = S_SRCH_CMP;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_SRCH_CMP: begin
        if (stat.match) begin
          ctl.wr_match = 1'b1;
          state_nxt    = S_COUNT;
        end else begin
          ctl.search_inc = 1'b1;
          state_nxt      = S_SRCH_RD;
        end
      end
      S_APPEND: begin
        ctl.wr_new = 1'b1;
        state_nxt  = S_COUNT;
      end
      S_COUNT: begin
        ctl.count_inc = 1'b1;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        // Hold until the result register is free
        if (!out_valid_r || out_ready) begin
          ctl.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### tb/sv/claim_retry_budget_tracker_test.sv
// Self-checking testbench for claim_retry_budget_tracker: directed and random commands,
// predicted results compared field by field. Depends on crt_pkg, crt_if and the RTL.
`timescale 1ns / 100ps

module claim_retry_budget_tracker_test;
  import crt_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 25;
  localparam int POOL_SIZE   = 12;
  localparam logic [CFG_ADDR_W-1:0] BUDGET_ADDR = CFG_ADDR_W'(4 * REG_RETRY_BUDGET);
  localparam logic [63:0] ALL_ONES = '1;

  typedef struct {
    cmd_t               cmd;
    logic [OP_W-1:0]    operation;
    logic [KEY_W-1:0]   key_id;
    logic [CH_W-1:0]    channel_id;
    logic               channel_present;
    logic [ARM_W-1:0]   arm;
    logic [CAUSE_W-1:0] cause;
    logic [IDX_W-1:0]   entry_index;
  } command_t;

  typedef struct {
    logic                exhausted;
    logic [BUDGET_W-1:0] refusal_count;
    logic [HELD_W-1:0]   entries_held;
    logic                entry_valid;
    logic [CH_W-1:0]     entry_channel;
    logic [ARM_W-1:0]    entry_arm;
    logic [CAUSE_W-1:0]  entry_cause;
  } result_t;

  // Track the retry budget state and the results it implies
  class retry_ledger;
    logic [BUDGET_W-1:0] budget;
    logic [OP_W-1:0]     op_now;
    logic [KEY_W-1:0]    key_now;
    logic [BUDGET_W-1:0] count;
    int                  fill;
    logic [CH_W-1:0]     ring_ch[RING_DEPTH];
    logic [ARM_W-1:0]    ring_arm[RING_DEPTH];
    logic [CAUSE_W-1:0]  ring_cause[RING_DEPTH];
    result_t             awaited[$];
    int                  errors;

    function new();
      budget = BUDGET_RESET;
      errors = 0;
      forget();
    endfunction

    function void forget();
      op_now  = '0;
      key_now = '0;
      count   = '0;
      fill    = 0;
    endfunction

    // Apply one accepted command and queue the result it must produce
    function void note_command(command_t c);
      result_t r;
      bit      hit;
      r   = '{default: '0};
      hit = 0;
      if (c.cmd == CMD_REFUSE) begin
        if (c.operation != '0) begin
          if (op_now != c.operation || key_now != c.key_id) begin
            forget();
            op_now  = c.operation;
            key_now = c.key_id;
          end
          if (c.channel_present) begin
            // Update the cause of a known pair, else append, dropping the oldest if full
            for (int i = 0; i < fill; i++) begin
              if (!hit && ring_ch[i] == c.channel_id && ring_arm[i] == c.arm) begin
                ring_cause[i] = c.cause;
                hit = 1;
              end
            end
            if (!hit) begin
              if (fill < RING_DEPTH) begin
                fill++;
              end else begin
                for (int i = 1; i < RING_DEPTH; i++) begin
                  ring_ch[i-1]    = ring_ch[i];
                  ring_arm[i-1]   = ring_arm[i];
                  ring_cause[i-1] = ring_cause[i];
                end
              end
              ring_ch[fill-1]    = c.channel_id;
              ring_arm[fill-1]   = c.arm;
              ring_cause[fill-1] = c.cause;
            end
          end
          if (count < budget) count++;
          r.exhausted = (count >= budget);
        end
      end else begin
        if (c.cmd == CMD_RESET) forget();
        if (c.cmd == CMD_READ && c.entry_index < fill) begin
          r.entry_valid   = 1'b1;
          r.entry_channel = ring_ch[c.entry_index];
          r.entry_arm     = ring_arm[c.entry_index];
          r.entry_cause   = ring_cause[c.entry_index];
        end
        r.exhausted = (op_now != '0 && count >= budget);
      end
      r.refusal_count = count;
      r.entries_held  = HELD_W'(fill);
      awaited.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string field, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h, want %0h", field, got, want));
    endtask

    // Compare one accepted result with the oldest prediction
    task check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        report("result transaction with no command outstanding");
      end else begin
        want = awaited.pop_front();
        compare_field("exhausted", got.exhausted, want.exhausted);
        compare_field("refusal_count", got.refusal_count, want.refusal_count);
        compare_field("entries_held", got.entries_held, want.entries_held);
        compare_field("entry_valid", got.entry_valid, want.entry_valid);
        compare_field("entry_channel", got.entry_channel, want.entry_channel);
        compare_field("entry_arm", got.entry_arm, want.entry_arm);
        compare_field("entry_cause", got.entry_cause, want.entry_cause);
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  crt_in_if  cmd_chan ();
  crt_out_if rsp_chan ();

  retry_ledger ledger;

  // Stimulus state: current logical operation and the channels that refuse it
  logic [OP_W-1:0]  cur_op;
  logic [KEY_W-1:0] cur_key;
  logic [CH_W-1:0]  chan_pool[POOL_SIZE];
  int               pool_size;
  int               burst_left = 0;
  int               quiet_cycles = 0;
  int               style_left = 0;
  int               stall_style = 0;
  int               hold_left = 0;

  claim_retry_budget_tracker u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (cmd_chan),
    .out_chan    (rsp_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (rst_n && rsp_chan.valid && rsp_chan.ready) begin
      ledger.check_result('{exhausted:     rsp_chan.exhausted,
                            refusal_count: rsp_chan.refusal_count,
                            entries_held:  rsp_chan.entries_held,
                            entry_valid:   rsp_chan.entry_valid,
                            entry_channel: rsp_chan.entry_channel,
                            entry_arm:     rsp_chan.entry_arm,
                            entry_cause:   rsp_chan.entry_cause});
    end
  end

  // Stall the result channel: always ready, coin flips or long holds, switched now and then
  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 2);
      style_left  = $urandom_range(50, 300);
    end
    style_left--;
    case (stall_style)
      0: begin
        rsp_chan.ready <= 1'b1;
      end
      1: begin
        rsp_chan.ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (hold_left > 0) begin
          rsp_chan.ready <= 1'b0;
          hold_left--;
        end else begin
          rsp_chan.ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) hold_left = $urandom_range(1, 25);
        end
      end
    endcase
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (cmd_chan.valid && cmd_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic command_t mk(cmd_t cmd, logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                  logic [CH_W-1:0] ch, logic present, logic [ARM_W-1:0] arm,
                                  logic [CAUSE_W-1:0] cause, logic [IDX_W-1:0] idx);
    command_t c;
    c = '{cmd, op, key, ch, present, arm, cause, idx};
    return c;
  endfunction

  // Draw fresh refusing channels; odd slots are often one bit off their neighbor
  function automatic void refill_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i % 2 == 1 && $urandom_range(0, 1) == 1)
        chan_pool[i] = chan_pool[i-1] ^ (64'd1 << $urandom_range(0, 63));
      else
        chan_pool[i] = {$urandom(), $urandom()};
    end
    pool_size = $urandom_range(2, POOL_SIZE);
  endfunction

  function automatic void switch_operation();
    cur_op = OP_W'($urandom_range(1, 3));
    if ($urandom_range(0, 1) == 1)
      cur_key = cur_key ^ (64'd1 << $urandom_range(0, 63));
    else
      cur_key = {$urandom(), $urandom()};
    if ($urandom_range(0, 1) == 1) refill_pool();
  endfunction

  // Mostly refusals of the current operation, with reads, resets, switches and noise
  function automatic command_t pick_command(bit long_run);
    command_t c;
    int       roll;
    c = mk(CMD_REFUSE, cur_op, cur_key, chan_pool[$urandom_range(0, pool_size - 1)],
           $urandom_range(0, 9) != 0, ARM_W'($urandom()), CAUSE_W'($urandom()),
           IDX_W'($urandom()));
    roll = $urandom_range(0, 99);
    if (long_run) begin
      if (roll < 15) c.cmd = CMD_READ;
    end else if (roll < 12) begin
      c.cmd = CMD_READ;
    end else if (roll < 16) begin
      c.cmd = CMD_RESET;
    end else if (roll < 22) begin
      switch_operation();
      c.operation = cur_op;
      c.key_id    = cur_key;
      c.channel_id = chan_pool[$urandom_range(0, pool_size - 1)];
    end else if (roll < 26) begin
      c.operation = '0;
    end else if (roll < 30) begin
      c.cmd        = cmd_t'($urandom_range(0, 2));
      c.operation  = OP_W'($urandom());
      c.key_id     = {$urandom(), $urandom()};
      c.channel_id = {$urandom(), $urandom()};
    end
    return c;
  endfunction

  // Present one command transaction, in bursts separated by random gaps
  task automatic send(input command_t c);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        cmd_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    cmd_chan.valid           <= 1'b1;
    cmd_chan.cmd             <= c.cmd;
    cmd_chan.operation       <= c.operation;
    cmd_chan.key_id          <= c.key_id;
    cmd_chan.channel_id      <= c.channel_id;
    cmd_chan.channel_present <= c.channel_present;
    cmd_chan.arm             <= c.arm;
    cmd_chan.cause           <= c.cause;
    cmd_chan.entry_index     <= c.entry_index;
    do @(posedge clk); while (!cmd_chan.ready);
    ledger.note_command(c);
    burst_left--;
  endtask

  task automatic drain();
    while (ledger.awaited.size() != 0) @(posedge clk);
  endtask

  // Write retry_budget once the block is idle
  task automatic set_budget(input logic [BUDGET_W-1:0] value);
    cmd_chan.valid <= 1'b0;
    drain();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= BUDGET_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    ledger.budget = value;
    burst_left    = 0;
  endtask

  task automatic run_phase(input logic [BUDGET_W-1:0] value, input int items,
                           input bit long_run);
    set_budget(value);
    if (long_run) switch_operation();
    repeat (items) send(pick_command(long_run));
  endtask

  initial begin
    ledger = new();
    rst_n                    = 1'b0;
    cfg_psel                 = 1'b0;
    cfg_penable              = 1'b0;
    cfg_pwrite               = 1'b0;
    cfg_paddr                = '0;
    cfg_pwdata               = '0;
    cmd_chan.valid           = 1'b0;
    cmd_chan.cmd             = CMD_REFUSE;
    cmd_chan.operation       = '0;
    cmd_chan.key_id          = '0;
    cmd_chan.channel_id      = '0;
    cmd_chan.channel_present = 1'b0;
    cmd_chan.arm             = '0;
    cmd_chan.cause           = '0;
    cmd_chan.entry_index     = '0;
    rsp_chan.ready           = 1'b0;
    cur_op                   = OP_W'(1);
    cur_key                  = {$urandom(), $urandom()};
    refill_pool();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty reads, spare command, ignored refusal, dedup, ring overflow
    set_budget(8'd20);
    send(mk(CMD_READ, 2'd0, 64'd0, 64'd0, 1'b0, 2'd0, 2'd0, 3'd0));
    send(mk(CMD_SPARE, 2'd3, ALL_ONES, ALL_ONES, 1'b1, 2'd3, 2'd3, 3'd7));
    send(mk(CMD_REFUSE, 2'd0, 64'h1234, ALL_ONES, 1'b1, 2'd3, 2'd3, 3'd7));
    send(mk(CMD_REFUSE, 2'd3, ALL_ONES, ALL_ONES, 1'b1, 2'd3, 2'd3, 3'd0));
    send(mk(CMD_REFUSE, 2'd3, ALL_ONES, 64'd0, 1'b1, 2'd0, 2'd0, 3'd0));
    send(mk(CMD_REFUSE, 2'd3, ALL_ONES, ALL_ONES, 1'b1, 2'd3, 2'd1, 3'd0));
    send(mk(CMD_REFUSE, 2'd3, ALL_ONES, 64'h5, 1'b0, 2'd2, 2'd2, 3'd0));
    for (int i = 1; i <= 7; i++) begin
      send(mk(CMD_REFUSE, 2'd3, ALL_ONES, 64'h1000 + i, 1'b1, ARM_W'(i), CAUSE_W'(i), 3'd0));
    end
    send(mk(CMD_READ, 2'd0, 64'd0, 64'd0, 1'b0, 2'd0, 2'd0, 3'd7));
    send(mk(CMD_READ, 2'd0, 64'd0, 64'd0, 1'b0, 2'd0, 2'd0, 3'd0));
    send(mk(CMD_READ, 2'd0, 64'd0, 64'd0, 1'b0, 2'd0, 2'd0, 3'd3));

    // Lower the budget below the count, then change operation and reset
    set_budget(8'd5);
    send(mk(CMD_REFUSE, 2'd3, ALL_ONES, 64'd0, 1'b1, 2'd0, 2'd2, 3'd0));
    send(mk(CMD_READ, 2'd0, 64'd0, 64'd0, 1'b0, 2'd0, 2'd0, 3'd0));
    send(mk(CMD_SPARE, 2'd0, 64'd0, 64'd0, 1'b0, 2'd0, 2'd0, 3'd0));
    send(mk(CMD_REFUSE, 2'd1, 64'd0, 64'h77, 1'b1, 2'd1, 2'd2, 3'd0));
    send(mk(CMD_REFUSE, 2'd1, 64'd0, 64'h78, 1'b0, 2'd2, 2'd1, 3'd0));
    send(mk(CMD_RESET, 2'd2, ALL_ONES, ALL_ONES, 1'b1, 2'd3, 2'd3, 3'd7));
    send(mk(CMD_READ, 2'd0, 64'd0, 64'd0, 1'b0, 2'd0, 2'd0, 3'd0));
    send(mk(CMD_REFUSE, 2'd2, {$urandom(), $urandom()}, 64'h99, 1'b1, 2'd1, 2'd3, 3'd0));

    // Random phases across budget settings, one long enough to saturate the count
    run_phase(8'd3, 220, 1'b0);
    run_phase(8'd255, 380, 1'b1);
    run_phase(8'd1, 200, 1'b0);
    run_phase(BUDGET_W'($urandom_range(2, 254)), 250, 1'b0);
    run_phase(BUDGET_W'($urandom_range(2, 16)), 400, 1'b0);

    // Let the last results arrive, then report
    cmd_chan.valid <= 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
